[rtl/tfp_pkg.sv]
package tfp_pkg;

  localparam int unsigned AngleBitsDefault = 16;
  localparam int unsigned CordicX0 = 652032874;

  typedef enum logic [2:0] {
    CfgFrontEdge = 3'd0,
    CfgRearEdge  = 3'd1,
    CfgLeftEdge  = 3'd2,
    CfgRightEdge = 3'd3,
    CfgBaseFront = 3'd4,
    CfgEgoX      = 3'd5,
    CfgEgoY      = 3'd6,
    CfgEgoYaw    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [15:0]        point_yaw;
    logic               first_point;
  } point_t;

  typedef struct packed {
    logic signed [31:0] c0_x;
    logic signed [31:0] c0_y;
    logic signed [31:0] c1_x;
    logic signed [31:0] c1_y;
    logic signed [31:0] c2_x;
    logic signed [31:0] c2_y;
    logic signed [31:0] c3_x;
    logic signed [31:0] c3_y;
    logic               empty_res;
  } result_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [15:0]        point_yaw;
    logic               cut;
  } task_t;

  typedef struct packed {
    logic signed [15:0] front_edge;
    logic signed [15:0] rear_edge;
    logic signed [15:0] left_edge;
    logic signed [15:0] right_edge;
    logic [14:0]        base_front;
    logic signed [31:0] ego_x;
    logic signed [31:0] ego_y;
    logic [15:0]        ego_yaw;
  } cfg_t;

  typedef enum logic [1:0] {
    FrIdle = 2'd0,
    FrSqrt = 2'd1,
    FrPush = 2'd2
  } front_state_e;

  typedef enum logic [3:0] {
    BkIdle  = 4'd0,
    BkCord1 = 4'd1,
    BkFx    = 4'd2,
    BkCord2 = 4'd3,
    BkMul   = 4'd4,
    BkSum   = 4'd5,
    BkOut   = 4'd6
  } back_state_e;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;  5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;  5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;  5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;  5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

[rtl/tfp_if.sv]
interface tfp_point_if;
  import tfp_pkg::*;
  logic   valid;
  logic   ready;
  point_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tfp_result_if;
  import tfp_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[rtl/tfp_front.sv]
module tfp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  tfp_point_if.sink         in_if,
  input  logic [14:0]       base_front_i,
  output logic              task_valid_o,
  output tfp_pkg::task_t    task_o,
  input  logic              task_ready_i
);
  import tfp_pkg::*;

  front_state_e state_q, state_d;
  logic signed [31:0] prev_x_q, prev_y_q;
  logic [31:0] travelled_q, travelled_d;
  logic cutting_q, cutting_d;
  task_t task_q, task_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] root_q, root_d;
  logic [63:0] bit_q, bit_d;
  logic [32:0] ax, ay;
  logic signed [32:0] dx, dy;
  logic [63:0] sq_x, sq_y;
  logic [32:0] tsum;
  logic accept;

  assign in_if.ready = (state_q == FrIdle);
  assign task_valid_o = (state_q == FrPush);
  assign accept = in_if.valid && in_if.ready;
  assign dx = 33'(in_if.data.point_x) - 33'(prev_x_q);
  assign dy = 33'(in_if.data.point_y) - 33'(prev_y_q);

  always_comb begin
    ax = dx[32] ? 33'(-dx) : 33'(dx);
    ay = dy[32] ? 33'(-dy) : 33'(dy);
    if (ax > 33'h080000000) ax = 33'h080000000;
    if (ay > 33'h080000000) ay = 33'h080000000;
    sq_x = 64'(ax) * 64'(ax);
    sq_y = 64'(ay) * 64'(ay);
  end

  always_comb begin
    state_d = state_q;
    travelled_d = travelled_q;
    cutting_d = cutting_q;
    task_d = task_q;
    rem_d = rem_q;
    root_d = root_q;
    bit_d = bit_q;
    tsum = 33'(travelled_q) + 33'(root_q);
    case (state_q)
      FrIdle: begin
        if (accept) begin
          task_d.point_x = in_if.data.point_x;
          task_d.point_y = in_if.data.point_y;
          task_d.point_yaw = in_if.data.point_yaw;
          if (in_if.data.first_point) begin
            travelled_d = '0;
            cutting_d = 1'b1;
            task_d.cut = 1'b1;
            state_d = FrPush;
          end else if (cutting_q) begin
            task_d.cut = 1'b1;
            rem_d = sq_x + sq_y;
            root_d = '0;
            bit_d = 64'h4000000000000000;
            state_d = FrSqrt;
          end else begin
            task_d.cut = 1'b0;
            state_d = FrPush;
          end
        end
      end
      FrSqrt: begin
        if (bit_q == '0) begin
          travelled_d = tsum[32] ? 32'hFFFFFFFF : tsum[31:0];
          if ((tsum[32] ? 32'hFFFFFFFF : tsum[31:0]) >= 32'(base_front_i)) begin
            cutting_d = 1'b0;
          end
          state_d = FrPush;
        end else begin
          if (rem_q >= root_q + bit_q) begin
            rem_d = rem_q - (root_q + bit_q);
            root_d = (root_q >> 1) + bit_q;
          end else begin
            root_d = root_q >> 1;
          end
          bit_d = bit_q >> 2;
        end
      end
      FrPush: begin
        if (task_ready_i) state_d = FrIdle;
      end
      default: state_d = FrIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
      prev_x_q <= '0;
      prev_y_q <= '0;
      travelled_q <= '0;
      cutting_q <= 1'b1;
    end else begin
      state_q <= state_d;
      travelled_q <= travelled_d;
      cutting_q <= cutting_d;
      if (accept) begin
        prev_x_q <= in_if.data.point_x;
        prev_y_q <= in_if.data.point_y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    task_q <= task_d;
    rem_q <= rem_d;
    root_q <= root_d;
    bit_q <= bit_d;
  end

  assign task_o = task_q;
endmodule

[rtl/tfp_queue.sv]
module tfp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  tfp_pkg::task_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output tfp_pkg::task_t rd_data_o
);
  import tfp_pkg::*;

  task_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

[rtl/tfp_cordic.sv]
module tfp_cordic #(
  parameter int unsigned ANGLE_BITS = tfp_pkg::AngleBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        yaw_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import tfp_pkg::*;

  localparam int unsigned CntW = $clog2(ANGLE_BITS + 1);

  logic busy_q;
  logic [CntW-1:0] cnt_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic neg_q;
  logic [31:0] ph;
  logic signed [33:0] z0, xs, ys;
  logic [4:0] idx;

  always_comb begin
    ph = {yaw_i, 16'h0000};
    ph = ph & ~(32'hFFFFFFFF >> ANGLE_BITS);
    z0 = 34'(signed'(ph));
    idx = 5'(cnt_q);
    xs = x_q >>> idx;
    ys = y_q >>> idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(ANGLE_BITS - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= 34'(CordicX0);
      y_q <= '0;
      neg_q <= 1'b0;
      if (z0 > 34'sh040000000) begin
        z_q <= z0 - 34'sh080000000;
        neg_q <= 1'b1;
      end else if (z0 < -34'sh040000000) begin
        z_q <= z0 + 34'sh080000000;
        neg_q <= 1'b1;
      end else begin
        z_q <= z0;
      end
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - 34'(atan_entry(idx));
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + 34'(atan_entry(idx));
      end
    end
  end

  assign cos_o = neg_q ? 32'(-x_q) : 32'(x_q);
  assign sin_o = neg_q ? 32'(-y_q) : 32'(y_q);
endmodule

[rtl/tfp_back.sv]
module tfp_back #(
  parameter int unsigned ANGLE_BITS = tfp_pkg::AngleBitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           task_valid_i,
  output logic           task_ready_o,
  input  tfp_pkg::task_t task_i,
  input  tfp_pkg::cfg_t  cfg_i,
  tfp_result_if.source   out_if
);
  import tfp_pkg::*;

  back_state_e state_q, state_d;
  task_t t_q;
  logic cstart;
  logic [15:0] cyaw;
  logic cdone;
  logic signed [31:0] ccos, csin;
  logic signed [31:0] cos_q, sin_q;
  logic empty_q;
  logic signed [33:0] lx_q [4];
  logic signed [15:0] ly [4];
  logic [1:0] k_q;
  logic signed [63:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [31:0] wx [4];
  logic signed [31:0] wy [4];
  logic signed [63:0] prod_fx;
  logic signed [33:0] fx_d;
  logic res_valid_q;
  result_t res_q;
  logic signed [65:0] sx, sy;
  logic signed [33:0] rx, ry;
  logic signed [31:0] satx, saty;

  assign ly[0] = cfg_i.left_edge;
  assign ly[1] = cfg_i.right_edge;
  assign ly[2] = cfg_i.right_edge;
  assign ly[3] = cfg_i.left_edge;

  tfp_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cstart), .yaw_i(cyaw), .done_o(cdone),
    .cos_o(ccos), .sin_o(csin)
  );

  assign task_ready_o = (state_q == BkIdle);
  assign out_if.valid = res_valid_q;
  assign out_if.data = res_q;

  always_comb begin
    prod_fx = 64'(ccos) * 64'(signed'({1'b0, cfg_i.base_front}));
    fx_d = 34'(t_q.point_x) - 34'(cfg_i.ego_x)
         + 34'((prod_fx + 64'sh20000000) >>> 30);
    sx = 66'(pa_q) - 66'(pb_q) + 66'sh20000000;
    sy = 66'(pc_q) + 66'(pd_q) + 66'sh20000000;
    rx = 34'(t_q.point_x) + 34'(sx >>> 30);
    ry = 34'(t_q.point_y) + 34'(sy >>> 30);
    satx = (rx > 34'sh07FFFFFFF) ? 32'sh7FFFFFFF :
           (rx < -34'sh080000000) ? 32'sh80000000 : 32'(rx);
    saty = (ry > 34'sh07FFFFFFF) ? 32'sh7FFFFFFF :
           (ry < -34'sh080000000) ? 32'sh80000000 : 32'(ry);
  end

  always_comb begin
    state_d = state_q;
    cstart = 1'b0;
    cyaw = t_q.point_yaw;
    case (state_q)
      BkIdle: if (task_valid_i) state_d = BkCord1;
      BkCord1: begin
        if (t_q.cut) begin
          cstart = 1'b1;
          cyaw = t_q.point_yaw - cfg_i.ego_yaw;
          state_d = BkFx;
        end else begin
          cstart = 1'b1;
          state_d = BkCord2;
        end
      end
      BkFx: begin
        if (cdone) begin
          cstart = 1'b1;
          state_d = BkCord2;
        end
      end
      BkCord2: if (cdone) state_d = BkMul;
      BkMul: state_d = BkSum;
      BkSum: state_d = (k_q == 2'd3) ? BkOut : BkMul;
      BkOut: if (!res_valid_q) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_if.valid && out_if.ready) res_valid_q <= 1'b0;
      if (state_q == BkOut && !res_valid_q) res_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BkIdle: begin
        t_q <= task_i;
        empty_q <= 1'b0;
        k_q <= '0;
        lx_q[0] <= 34'(cfg_i.front_edge);
        lx_q[1] <= 34'(cfg_i.front_edge);
        lx_q[2] <= 34'(cfg_i.rear_edge);
        lx_q[3] <= 34'(cfg_i.rear_edge);
      end
      BkFx: begin
        if (cdone) begin
          if (fx_d >= 34'(cfg_i.front_edge)) empty_q <= 1'b1;
          for (int i = 0; i < 4; i++) begin
            if (fx_d > lx_q[i]) lx_q[i] <= fx_d;
          end
        end
      end
      BkCord2: begin
        if (cdone) begin
          cos_q <= ccos;
          sin_q <= csin;
        end
      end
      BkMul: begin
        pa_q <= 64'(lx_q[k_q]) * 64'(cos_q);
        pb_q <= 64'(ly[k_q]) * 64'(sin_q);
        pc_q <= 64'(lx_q[k_q]) * 64'(sin_q);
        pd_q <= 64'(ly[k_q]) * 64'(cos_q);
      end
      BkSum: begin
        wx[k_q] <= empty_q ? 32'sh0 : satx;
        wy[k_q] <= empty_q ? 32'sh0 : saty;
        k_q <= k_q + 2'd1;
      end
      BkOut: begin
        if (!res_valid_q) begin
          res_q.c0_x <= wx[0]; res_q.c0_y <= wy[0];
          res_q.c1_x <= wx[1]; res_q.c1_y <= wy[1];
          res_q.c2_x <= wx[2]; res_q.c2_y <= wy[2];
          res_q.c3_x <= wx[3]; res_q.c3_y <= wy[3];
          res_q.empty_res <= empty_q;
        end
      end
      default: ;
    endcase
  end
endmodule

[rtl/trajectory_footprint_projector.sv]
// Projects the vehicle rectangle onto each trajectory point. A point still in
// the cut zone passes an integer square root in the front part, then two
// CORDIC runs and a multiply and a sum step for each of the four corners in
// the back part. A first point skips the square root, and a point past the
// cut zone needs one CORDIC run.
// A two-entry queue sits between the parts; the back part loads the result
// register and goes idle once an earlier result has been taken.
module trajectory_footprint_projector #(
  parameter int unsigned ANGLE_BITS = tfp_pkg::AngleBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tfp_point_if.sink  in_if,
  tfp_cfg_if.sink    cfg_if,
  tfp_result_if.source out_if
);
  import tfp_pkg::*;

  cfg_t cfg_q;
  logic q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
  task_t q_wr_data, q_rd_data;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.front_edge <= 16'sd4000;
      cfg_q.rear_edge <= -16'sd1000;
      cfg_q.left_edge <= 16'sd1000;
      cfg_q.right_edge <= -16'sd1000;
      cfg_q.base_front <= 15'd4000;
      cfg_q.ego_x <= '0;
      cfg_q.ego_y <= '0;
      cfg_q.ego_yaw <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_idx_e'(cfg_if.index))
        CfgFrontEdge: cfg_q.front_edge <= cfg_if.wdata[15:0];
        CfgRearEdge:  cfg_q.rear_edge <= cfg_if.wdata[15:0];
        CfgLeftEdge:  cfg_q.left_edge <= cfg_if.wdata[15:0];
        CfgRightEdge: cfg_q.right_edge <= cfg_if.wdata[15:0];
        CfgBaseFront: cfg_q.base_front <= cfg_if.wdata[14:0];
        CfgEgoX:      cfg_q.ego_x <= cfg_if.wdata;
        CfgEgoY:      cfg_q.ego_y <= cfg_if.wdata;
        CfgEgoYaw:    cfg_q.ego_yaw <= cfg_if.wdata[15:0];
        default: ;
      endcase
    end
  end

  tfp_front u_front (
    .clk_i, .rst_ni, .in_if,
    .base_front_i(cfg_q.base_front),
    .task_valid_o(q_wr_valid), .task_o(q_wr_data), .task_ready_i(q_wr_ready)
  );

  tfp_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(q_wr_valid), .wr_ready_o(q_wr_ready), .wr_data_i(q_wr_data),
    .rd_valid_o(q_rd_valid), .rd_ready_i(q_rd_ready), .rd_data_o(q_rd_data)
  );

  tfp_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk_i, .rst_ni,
    .task_valid_i(q_rd_valid), .task_ready_o(q_rd_ready), .task_i(q_rd_data),
    .cfg_i(cfg_q), .out_if
  );
endmodule

[test/tfp_checker.sv]
module tfp_checker #(
  parameter int unsigned ANGLE_BITS = tfp_pkg::AngleBitsDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  tfp_point_if   pt_if,
  tfp_cfg_if     cf_if,
  tfp_result_if  rs_if,
  output int     pending_o,
  output int     errors_o,
  output int     cut_cnt_o,
  output int     empty_cnt_o
);
  import tfp_pkg::*;

  localparam longint Half = longint'(1) <<< 29;

  const longint unsigned atan_q32[32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  cfg_t    cfg;
  longint  last_x, last_y;
  longint unsigned dist_sum;
  bit      in_cut_zone;
  result_t footprint_q[$];
  int      n_in, n_out;

  assign pending_o = n_in - n_out;

  function automatic void sin_cos(input logic [15:0] yaw, output longint c, output longint s);
    logic [31:0] ph;
    longint x, y, z, xs, ys;
    bit flip;
    ph = {yaw, 16'h0} & ~(32'hFFFF_FFFF >> ANGLE_BITS);
    z = longint'(ph);
    if (z >= (longint'(1) <<< 31)) z -= longint'(1) <<< 32;
    flip = 0;
    if (z > (longint'(1) <<< 30)) begin
      z -= longint'(1) <<< 31;
      flip = 1;
    end else if (z < -(longint'(1) <<< 30)) begin
      z += longint'(1) <<< 31;
      flip = 1;
    end
    x = 652032874;
    y = 0;
    for (int i = 0; i < ANGLE_BITS; i++) begin
      xs = x >>> (i % 32);
      ys = y >>> (i % 32);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_q32[i % 32]);
      end else begin
        x += ys; y -= xs; z += longint'(atan_q32[i % 32]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag_clamp(input longint d);
    longint unsigned a;
    a = (d < 0) ? longint'(-d) : d;
    return (a > (64'd1 << 31)) ? (64'd1 << 31) : a;
  endfunction

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic result_t project_point(input point_t p);
    result_t r;
    longint px, py, c, s, cd, sd, fx, wx, wy, ax, ay;
    longint lx[4], ly[4];
    longint unsigned sum;
    bit cut, empty;
    px = p.point_x;
    py = p.point_y;
    cut = 0;
    empty = 0;
    if (p.first_point) begin
      dist_sum = 0;
      in_cut_zone = 1;
      cut = 1;
    end else if (in_cut_zone) begin
      ax = mag_clamp(px - last_x);
      ay = mag_clamp(py - last_y);
      sum = dist_sum + int_sqrt(ax * ax + ay * ay);
      dist_sum = (sum > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : sum;
      cut = 1;
      if (dist_sum >= longint'(cfg.base_front)) in_cut_zone = 0;
    end
    last_x = px;
    last_y = py;
    lx[0] = cfg.front_edge; ly[0] = cfg.left_edge;
    lx[1] = cfg.front_edge; ly[1] = cfg.right_edge;
    lx[2] = cfg.rear_edge;  ly[2] = cfg.right_edge;
    lx[3] = cfg.rear_edge;  ly[3] = cfg.left_edge;
    if (cut) begin
      sin_cos(p.point_yaw - cfg.ego_yaw, cd, sd);
      fx = (px - longint'(cfg.ego_x)) + ((cd * longint'(cfg.base_front) + Half) >>> 30);
      if (fx >= longint'(cfg.front_edge)) empty = 1;
      else for (int k = 0; k < 4; k++) if (fx > lx[k]) lx[k] = fx;
    end
    sin_cos(p.point_yaw, c, s);
    r = '0;
    if (!empty) begin
      r.c0_x = clip32(px + ((lx[0] * c - ly[0] * s + Half) >>> 30));
      r.c0_y = clip32(py + ((lx[0] * s + ly[0] * c + Half) >>> 30));
      r.c1_x = clip32(px + ((lx[1] * c - ly[1] * s + Half) >>> 30));
      r.c1_y = clip32(py + ((lx[1] * s + ly[1] * c + Half) >>> 30));
      r.c2_x = clip32(px + ((lx[2] * c - ly[2] * s + Half) >>> 30));
      r.c2_y = clip32(py + ((lx[2] * s + ly[2] * c + Half) >>> 30));
      r.c3_x = clip32(px + ((lx[3] * c - ly[3] * s + Half) >>> 30));
      r.c3_y = clip32(py + ((lx[3] * s + ly[3] * c + Half) >>> 30));
    end
    r.empty_res = empty;
    if (cut) cut_cnt_o++;
    if (empty) empty_cnt_o++;
    return r;
  endfunction

  task automatic cmp(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t e, a;
    if (!rst_ni) begin
      cfg.front_edge <= 16'sd4000;
      cfg.rear_edge  <= -16'sd1000;
      cfg.left_edge  <= 16'sd1000;
      cfg.right_edge <= -16'sd1000;
      cfg.base_front <= 15'd4000;
      cfg.ego_x      <= '0;
      cfg.ego_y      <= '0;
      cfg.ego_yaw    <= '0;
      last_x = 0;
      last_y = 0;
      dist_sum = 0;
      in_cut_zone = 1;
      footprint_q.delete();
      n_in <= 0;
      n_out <= 0;
      errors_o <= 0;
      cut_cnt_o <= 0;
      empty_cnt_o <= 0;
    end else begin
      if (cf_if.valid && cf_if.ready) begin
        case (cfg_idx_e'(cf_if.index))
          CfgFrontEdge: cfg.front_edge <= cf_if.wdata[15:0];
          CfgRearEdge:  cfg.rear_edge  <= cf_if.wdata[15:0];
          CfgLeftEdge:  cfg.left_edge  <= cf_if.wdata[15:0];
          CfgRightEdge: cfg.right_edge <= cf_if.wdata[15:0];
          CfgBaseFront: cfg.base_front <= cf_if.wdata[14:0];
          CfgEgoX:      cfg.ego_x      <= cf_if.wdata;
          CfgEgoY:      cfg.ego_y      <= cf_if.wdata;
          CfgEgoYaw:    cfg.ego_yaw    <= cf_if.wdata[15:0];
          default: ;
        endcase
      end
      if (pt_if.valid && pt_if.ready) begin
        footprint_q = {footprint_q, project_point(pt_if.data)};
        n_in <= n_in + 1;
      end
      if (rs_if.valid && rs_if.ready) begin
        n_out <= n_out + 1;
        a = rs_if.data;
        if (footprint_q.size() == 0) begin
          $error("footprint transaction with nothing expected");
          errors_o++;
        end else begin
          e = footprint_q.pop_front();
          cmp("c0_x", e.c0_x, a.c0_x);
          cmp("c0_y", e.c0_y, a.c0_y);
          cmp("c1_x", e.c1_x, a.c1_x);
          cmp("c1_y", e.c1_y, a.c1_y);
          cmp("c2_x", e.c2_x, a.c2_x);
          cmp("c2_y", e.c2_y, a.c2_y);
          cmp("c3_x", e.c3_x, a.c3_x);
          cmp("c3_y", e.c3_y, a.c3_y);
          cmp("empty_res", e.empty_res, a.empty_res);
        end
      end
    end
  end

endmodule

[test/tb_top.sv]
module tb_top;
  import tfp_pkg::*;

  localparam int StallLimit = 3000;

  logic clk_i = 0;
  logic rst_ni = 0;

  tfp_point_if  pt_if ();
  tfp_cfg_if    cf_if ();
  tfp_result_if rs_if ();

  int pending, errors, cut_cnt, empty_cnt;
  int n_points, quiet, stall_left;
  bit calm;

  always #5 clk_i = ~clk_i;

  trajectory_footprint_projector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (pt_if),
    .cfg_if (cf_if),
    .out_if (rs_if)
  );

  tfp_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pt_if       (pt_if),
    .cf_if       (cf_if),
    .rs_if       (rs_if),
    .pending_o   (pending),
    .errors_o    (errors),
    .cut_cnt_o   (cut_cnt),
    .empty_cnt_o (empty_cnt)
  );

  initial begin
    pt_if.valid = 0;
    pt_if.data  = '0;
    cf_if.valid = 0;
    cf_if.index = '0;
    cf_if.wdata = '0;
    rs_if.ready = 0;
  end

  function automatic int gap_len();
    if (calm) return 0;
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  // result side back-pressure
  always @(posedge clk_i) begin
    logic rdy;
    rdy = 1;
    if (stall_left > 0) begin
      stall_left--;
      rdy = 0;
    end else if (!calm && $urandom_range(9) < 3) begin
      stall_left = ($urandom_range(9) < 8) ? $urandom_range(3) : $urandom_range(60, 4);
      rdy = (stall_left == 0);
    end
    rs_if.ready <= rdy;
  end

  // no transaction at all for too long
  always @(posedge clk_i) begin
    if ((pt_if.valid && pt_if.ready) || (cf_if.valid && cf_if.ready) ||
        (rs_if.valid && rs_if.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_point(input longint x, input longint y, input logic [15:0] yaw,
                            input bit first);
    point_t p;
    int g;
    p.point_x = (x > 64'sd2147483647) ? 32'h7FFF_FFFF :
                (x < -64'sd2147483648) ? 32'h8000_0000 : x[31:0];
    p.point_y = (y > 64'sd2147483647) ? 32'h7FFF_FFFF :
                (y < -64'sd2147483648) ? 32'h8000_0000 : y[31:0];
    p.point_yaw = yaw;
    p.first_point = first;
    pt_if.valid <= 1;
    pt_if.data <= p;
    do @(posedge clk_i); while (!pt_if.ready);
    n_points++;
    g = gap_len();
    if (g > 0) begin
      pt_if.valid <= 0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] v);
    cf_if.valid <= 1;
    cf_if.index <= idx;
    cf_if.wdata <= v;
    do @(posedge clk_i); while (!cf_if.ready);
    cf_if.valid <= 0;
  endtask

  task automatic drain();
    pt_if.valid <= 0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  task automatic set_all(input int fe, input int re, input int le, input int ri,
                         input int bf, input int ex, input int ey, input int eyaw);
    write_reg(CfgFrontEdge, fe);
    write_reg(CfgRearEdge, re);
    write_reg(CfgLeftEdge, le);
    write_reg(CfgRightEdge, ri);
    write_reg(CfgBaseFront, bf);
    write_reg(CfgEgoX, ex);
    write_reg(CfgEgoY, ey);
    write_reg(CfgEgoYaw, eyaw);
  endtask

  task automatic run_trajectories(input int n_items, input longint ex, input longint ey);
    longint x, y;
    logic [15:0] yaw;
    int left;
    left = 0;
    x = ex;
    y = ey;
    yaw = 0;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(19) == 0) begin
        // noise: any field value
        send_point(longint'(signed'($urandom())), longint'(signed'($urandom())),
                   16'($urandom()), 1'($urandom_range(1)));
      end else begin
        if (left == 0) begin
          left = $urandom_range(40, 3);
          x = ex + $urandom_range(6000) - 3000;
          y = ey + $urandom_range(6000) - 3000;
          yaw = 16'($urandom());
          send_point(x, y, yaw, $urandom_range(9) != 0);
        end else begin
          x += longint'($urandom_range(3000)) - 1500;
          y += longint'($urandom_range(3000)) - 1500;
          yaw += 16'($urandom_range(4000) - 2000);
          send_point(x, y, yaw, 0);
        end
        left--;
      end
    end
    drain();
  endtask

  initial begin
    longint ex, ey;
    n_points = 0;
    quiet = 0;
    stall_left = 0;
    calm = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // reset settings, no first point yet
    send_point(1000, 0, 0, 0);
    send_point(5000, 0, 0, 0);
    send_point(0, 0, 0, 1);
    send_point(2000, 0, 16'h4000, 0);
    send_point(6000, 100, 16'h8000, 0);
    send_point(9000, 200, 16'hC000, 0);
    send_point(0, 0, 16'hFFFF, 1);
    send_point(-64'sd2147483648, 64'sd2147483647, 16'h2000, 0);
    send_point(64'sd2147483647, -64'sd2147483648, 16'hA000, 0);
    send_point(64'sd2147483647, 64'sd2147483647, 16'h0000, 1);
    send_point(-5000, -5000, 16'h6000, 1);
    send_point(-3000, -5000, 16'hE000, 0);
    drain();

    // extremes: wide box, reversed box, zero front reach
    set_all(32767, -32768, 32767, -32768, 32767, 0, 0, 16'h8000);
    send_point(64'sd2147483647, 64'sd2147483647, 16'h2000, 1);
    send_point(-64'sd2147483648, -64'sd2147483648, 16'hA000, 0);
    send_point(-64'sd2147483648, 64'sd2147483647, 16'h8000, 1);
    send_point(-100000, 0, 16'h8000, 1);
    send_point(-90000, 0, 16'h7FFF, 0);
    drain();
    set_all(-32768, 32767, -32768, 32767, 0, -2147483648, 2147483647, 16'hFFFF);
    send_point(-64'sd2147483648, 64'sd2147483647, 16'hFFFF, 1);
    send_point(0, 0, 16'h0001, 0);
    send_point(64'sd2147483647, 0, 16'h4000, 0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph == 3 || ph == 7);
      ex = (ph == 5) ? longint'(signed'($urandom())) :
           longint'($urandom_range(200000)) - 100000;
      ey = longint'($urandom_range(200000)) - 100000;
      if (ph == 8) set_all(32767, 32767, -32768, -32768, 32767, int'(ex), int'(ey),
                           $urandom());
      else set_all($urandom_range(8000, 0), -$urandom_range(3000), $urandom_range(1500),
                   -$urandom_range(1500), (ph == 2) ? 0 : $urandom_range(8000),
                   int'(ex), int'(ey), $urandom());
      run_trajectories(180, ex, ey);
    end

    calm = 0;
    drain();
    repeat (100) @(posedge clk_i);
    $display("covered %0d points over 13 register settings", n_points);
    $display("cut points %0d, empty footprints %0d", cut_cnt, empty_cnt);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

[trajectory_footprint_projector.f]
rtl/tfp_pkg.sv
rtl/tfp_if.sv
rtl/tfp_front.sv
rtl/tfp_queue.sv
rtl/tfp_cordic.sv
rtl/tfp_back.sv
rtl/trajectory_footprint_projector.sv
test/tfp_checker.sv
test/tb_top.sv
